// File: hdl/utf8_ucs4_transcoder_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 / UCS-4 transcoder assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_UCS4_TRANSCODER_MACROS_SVH
`define UTF8_UCS4_TRANSCODER_MACROS_SVH

// same-cycle implication
`define U8TC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define U8TC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/u8tc_pkg.sv
// ----------------------------------------------------------------------------
// u8tc_pkg
// Types and constants shared by the UTF-8 / UCS-4 transcoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package u8tc_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CODE_W = 31;
    localparam int unsigned CNT_W  = 3;

    localparam logic DIR_DECODE = 1'b0;
    localparam logic DIR_ENCODE = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_TRUNC = 1'b1;

    localparam logic [WORD_W-1:0] LIMIT_1B = 32'h0000_0080;
    localparam logic [WORD_W-1:0] LIMIT_2B = 32'h0000_0800;
    localparam logic [WORD_W-1:0] LIMIT_3B = 32'h0001_0000;
    localparam logic [WORD_W-1:0] LIMIT_4B = 32'h0020_0000;
    localparam logic [WORD_W-1:0] LIMIT_5B = 32'h0400_0000;

    localparam logic [1:0] CONT_TAG = 2'b10;

    typedef struct packed {
        logic              emit;
        logic [WORD_W-1:0] value;
        logic              last;
        logic              status;
        logic              done;
    } res_t;

endpackage

`default_nettype wire

// File: hdl/u8tc_decoder.sv
// ----------------------------------------------------------------------------
// u8tc_decoder
// UTF-8 byte decoder step with partial code point and pending count state.
// ----------------------------------------------------------------------------
`default_nettype none

module u8tc_decoder
    import u8tc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [7:0]  byte_in,
    input  wire logic        end_in,
    output res_t             res
);

    logic [CODE_W-1:0] partial_reg;
    logic [CODE_W-1:0] partial_next;
    logic [CNT_W-1:0]  pending_reg;
    logic [CNT_W-1:0]  pending_next;

    always_comb
    begin
        partial_next = partial_reg;
        pending_next = pending_reg;
        res.emit     = 1'b0;
        res.value    = '0;
        res.last     = 1'b1;
        res.status   = STATUS_OK;
        res.done     = 1'b1;
        if (pending_reg != '0)
        begin
            partial_next = {partial_reg[CODE_W-7:0], byte_in[5:0]};
            pending_next = pending_reg - CNT_W'(1);
            if (pending_reg == CNT_W'(1))
            begin
                res.emit     = 1'b1;
                res.value    = {1'b0, partial_next};
                partial_next = '0;
            end
        end
        else if (byte_in inside {[8'h00:8'h7f]})
        begin
            res.emit  = 1'b1;
            res.value = {24'd0, byte_in};
        end
        else if (byte_in inside {[8'hc0:8'hdf]})
        begin
            partial_next = CODE_W'(byte_in[4:0]);
            pending_next = CNT_W'(1);
        end
        else if (byte_in inside {[8'he0:8'hef]})
        begin
            partial_next = CODE_W'(byte_in[3:0]);
            pending_next = CNT_W'(2);
        end
        else if (byte_in inside {[8'hf0:8'hf7]})
        begin
            partial_next = CODE_W'(byte_in[2:0]);
            pending_next = CNT_W'(3);
        end
        else if (byte_in inside {[8'hf8:8'hfb]})
        begin
            partial_next = CODE_W'(byte_in[1:0]);
            pending_next = CNT_W'(4);
        end
        else if (byte_in inside {[8'hfc:8'hfd]})
        begin
            partial_next = CODE_W'(byte_in[0]);
            pending_next = CNT_W'(5);
        end
        else
        begin
            res.emit  = 1'b1;
            res.value = {24'd0, byte_in};
        end
        // drop an unfinished sequence at end of stream
        if (end_in && !res.emit && pending_next != '0)
        begin
            partial_next = '0;
            pending_next = '0;
            res.emit     = 1'b1;
            res.value    = '0;
            res.status   = STATUS_TRUNC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pending_reg <= '0;
        end
        else if (go)
        begin
            partial_reg <= partial_next;
            pending_reg <= pending_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/u8tc_encoder.sv
// ----------------------------------------------------------------------------
// u8tc_encoder
// UCS-4 word to UTF-8 byte serializer, one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module u8tc_encoder
    import u8tc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              go,
    input  wire logic [WORD_W-1:0] word,
    output res_t                   res
);

    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [CNT_W-1:0] extra;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] sel;
    logic [5:0]       slice;
    logic [7:0]       lead;

    always_comb
    begin
        if (word < LIMIT_1B)
            extra = CNT_W'(0);
        else if (word < LIMIT_2B)
            extra = CNT_W'(1);
        else if (word < LIMIT_3B)
            extra = CNT_W'(2);
        else if (word < LIMIT_4B)
            extra = CNT_W'(3);
        else if (word < LIMIT_5B)
            extra = CNT_W'(4);
        else
            extra = CNT_W'(5);
        count = word[WORD_W-1] ? '0 : extra + CNT_W'(1);

        case (extra)
            CNT_W'(1): lead = {3'b110, word[10:6]};
            CNT_W'(2): lead = {4'b1110, word[15:12]};
            CNT_W'(3): lead = {5'b11110, word[20:18]};
            CNT_W'(4): lead = {6'b111110, word[25:24]};
            CNT_W'(5): lead = {7'b1111110, word[30]};
            default:   lead = word[7:0];
        endcase

        sel = extra - idx_reg;
        case (sel)
            CNT_W'(0): slice = word[5:0];
            CNT_W'(1): slice = word[11:6];
            CNT_W'(2): slice = word[17:12];
            CNT_W'(3): slice = word[23:18];
            CNT_W'(4): slice = word[29:24];
            default:   slice = '0;
        endcase

        res.emit   = (count != '0);
        res.status = STATUS_OK;
        res.done   = (count == '0) || (idx_reg == count - CNT_W'(1));
        res.last   = res.done;
        if (idx_reg == '0)
            res.value = {24'd0, lead};
        else
            res.value = {24'd0, CONT_TAG, slice};

        idx_next = res.done ? '0 : idx_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (go)
            idx_reg <= idx_next;
    end

endmodule

`default_nettype wire

// File: hdl/utf8_ucs4_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_ucs4_transcoder
// UTF-8 (six-byte form) to UCS-4 decoder and UCS-4 to UTF-8 encoder.
// ----------------------------------------------------------------------------
// Usage:
//   Input words enter on in_valid/in_ready, results leave on out_valid/
//   out_ready. cfg_write_en with cfg_write_data selects decode (0) or
//   encode (1); write it only while the block is idle.
//   A word is captured in an input register, processed by one level of
//   logic and placed in the output register.
//   Decode: one byte per cycle sustained while the output does not stall,
//   at most one result per byte.
//   Encode: 1 to 6 output bytes per word, set by the byte serializer; the
//   next word is taken only as the last byte leaves; words at or above
//   0x80000000 pass with no result.
//   Reset clears the direction, the decode and encode state and the valid flags of both registers.
//   When out_ready is low the output register holds, the input register
//   fills, and in_ready drops until the receiver takes the pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_ucs4_transcoder
    import u8tc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_en,
    input  wire logic              cfg_write_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [WORD_W-1:0] in_value,
    input  wire logic              in_end,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [WORD_W-1:0]      out_value,
    output logic                   out_last,
    output logic                   out_status
);

    logic              dir_reg;
    logic              a_valid_reg;
    logic [WORD_W-1:0] a_value_reg;
    logic              a_end_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] out_value_reg;
    logic              out_last_reg;
    logic              out_status_reg;
    logic              out_open;
    logic              a_fire;
    logic              in_fire;
    res_t              dec_res;
    res_t              enc_res;
    res_t              sel_res;

    assign out_open = !out_valid_reg || out_ready;
    assign a_fire   = a_valid_reg && out_open;
    assign sel_res  = (dir_reg == DIR_ENCODE) ? enc_res : dec_res;
    assign in_ready = !a_valid_reg || (a_fire && sel_res.done);
    assign in_fire  = in_valid && in_ready;

    u8tc_decoder u_dec (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (a_fire && (dir_reg == DIR_DECODE)),
        .byte_in (a_value_reg[7:0]),
        .end_in  (a_end_reg),
        .res     (dec_res)
    );

    u8tc_encoder u_enc (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (a_fire && (dir_reg == DIR_ENCODE)),
        .word  (a_value_reg),
        .res   (enc_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_open)
            out_valid_next = a_fire && sel_res.emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg       <= DIR_DECODE;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                dir_reg <= cfg_write_data;
            if (in_ready)
                a_valid_reg <= in_valid;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_value_reg <= in_value;
            a_end_reg   <= in_end;
        end
        if (a_fire && sel_res.emit)
        begin
            out_value_reg  <= sel_res.value;
            out_last_reg   <= sel_res.last;
            out_status_reg <= sel_res.status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_last   = out_last_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

// File: hdl/u8tc_checker.sv
// ----------------------------------------------------------------------------
// u8tc_checker
// Port-level checks for the UTF-8 / UCS-4 transcoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_ucs4_transcoder_macros.svh"

module u8tc_checker
    import u8tc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write_en,
    input  wire logic              cfg_write_data,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic [WORD_W-1:0] out_value,
    input  wire logic              out_last,
    input  wire logic              out_status
);

    logic dir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dir_reg <= DIR_DECODE;
        else if (cfg_write_en)
            dir_reg <= cfg_write_data;
    end

    `U8TC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_last), "output word changed while stalled")
    `U8TC_ASSERT_IMPL(a_trunc_form, out_valid && out_status == STATUS_TRUNC, out_last && out_value == '0 && dir_reg == DIR_DECODE, "truncation word malformed")
    `U8TC_ASSERT_IMPL(a_code_range, out_valid && dir_reg == DIR_DECODE, !out_value[WORD_W-1] && out_last, "decoded word out of range")
    `U8TC_ASSERT_IMPL(a_enc_multi, out_valid && dir_reg == DIR_ENCODE && !out_last, out_value[WORD_W-1:8] == '0 && out_value[7], "encoded non-final byte malformed")

endmodule

bind utf8_ucs4_transcoder u8tc_checker u_chk (.*);

`default_nettype wire
